@@ sv/ubmm_pkg.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: shared package
// Field widths, command codes, controller states and the lane selection
// record that passes from the controller to the lane merge logic.
// ----------------------------------------------------------------------------
package ubmm_pkg;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 32;
  localparam int BE_W   = 4;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_INDEX,
    ST_READ,
    ST_MODIFY
  } state_t;

  // Which bank holds the first addressed word, and the byte offset within it.
  typedef struct packed {
    logic       first_odd;
    logic [1:0] offset;
  } lane_sel_t;

endpackage

@@ sv/ubmm_bank.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: word bank
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module ubmm_bank #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ubmm_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [ubmm_pkg::DATA_W-1:0] rd_data
);

  logic [ubmm_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/ubmm_addr_reduce.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: address reduction
// Takes the byte address modulo the memory span in two registered steps:
// a reciprocal multiply for the quotient, then a multiply and subtract.
// ----------------------------------------------------------------------------
module ubmm_addr_reduce #(
  parameter int SPAN = 4096
) (
  input  logic                       clk,
  input  logic [ubmm_pkg::ADDR_W-1:0] addr,
  output logic [ubmm_pkg::ADDR_W-1:0] addr_mod
);

  // With a 24-bit scale the quotient of a 12-bit address is exact for any span
  // in range, so no correction step is needed afterwards.
  localparam int SH      = 24;
  localparam int RECIP   = (2**SH + SPAN - 1) / SPAN;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = ubmm_pkg::ADDR_W + RECIP_W;

  logic [PROD_W-1:0]           prod;
  logic [ubmm_pkg::ADDR_W-1:0] quot;
  logic [ubmm_pkg::ADDR_W-1:0] addr_d;
  logic [31:0]                 rem_wide;

  assign prod     = PROD_W'(addr) * PROD_W'(RECIP);
  assign rem_wide = 32'(addr_d) - 32'(quot) * 32'(SPAN);

  always_ff @(posedge clk) begin
    quot     <= ubmm_pkg::ADDR_W'(prod >> SH);
    addr_d   <= addr;
    addr_mod <= ubmm_pkg::ADDR_W'(rem_wide);
  end

endmodule

@@ sv/ubmm_merge.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: lane merge
// Orders the two bank words, assembles read data and merges masked write
// bytes into both words.
// ----------------------------------------------------------------------------
module ubmm_merge (
  input  ubmm_pkg::lane_sel_t          sel,
  input  logic [ubmm_pkg::DATA_W-1:0]  even_word,
  input  logic [ubmm_pkg::DATA_W-1:0]  odd_word,
  input  logic [ubmm_pkg::DATA_W-1:0]  write_data,
  input  logic [ubmm_pkg::BE_W-1:0]    byte_enable,
  output logic [ubmm_pkg::DATA_W-1:0]  read_data,
  output logic [ubmm_pkg::DATA_W-1:0]  new_even,
  output logic [ubmm_pkg::DATA_W-1:0]  new_odd
);

  localparam int PAIR_W  = 2 * ubmm_pkg::DATA_W;
  localparam int LANES   = 2 * ubmm_pkg::BE_W;

  logic [ubmm_pkg::DATA_W-1:0] w_lo;
  logic [ubmm_pkg::DATA_W-1:0] w_hi;
  logic [PAIR_W-1:0]           pair;
  logic [PAIR_W-1:0]           data_sh;
  logic [PAIR_W-1:0]           mask;
  logic [PAIR_W-1:0]           merged;
  logic [LANES-1:0]            en_sh;
  logic [4:0]                  bit_sh;

  assign w_lo   = sel.first_odd ? odd_word  : even_word;
  assign w_hi   = sel.first_odd ? even_word : odd_word;
  assign pair   = {w_hi, w_lo};
  assign bit_sh = {sel.offset, 3'b000};

  assign read_data = ubmm_pkg::DATA_W'(pair >> bit_sh);

  assign en_sh   = LANES'(byte_enable) << sel.offset;
  assign data_sh = PAIR_W'(write_data) << bit_sh;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mask[8*i +: 8] = {8{en_sh[i]}};
    end
  end

  assign merged   = (pair & ~mask) | (data_sh & mask);
  assign new_even = sel.first_odd ? merged[PAIR_W-1:ubmm_pkg::DATA_W]
                                  : merged[ubmm_pkg::DATA_W-1:0];
  assign new_odd  = sel.first_odd ? merged[ubmm_pkg::DATA_W-1:0]
                                  : merged[PAIR_W-1:ubmm_pkg::DATA_W];

endmodule

@@ sv/unaligned_byte_masked_memory_top.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: top level
// Sequence: an accepted beat passes through the reduce, index, read and
// modify states, and the result strobe is registered from the modify state;
// the next beat can be accepted in the same cycle as the strobe, so a
// new access waits until the last is through. The receiver cannot stall.
// Reset: a clearing pass zeroes both banks, during which busy stays high.
// ----------------------------------------------------------------------------
module unaligned_byte_masked_memory_top #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [ubmm_pkg::ADDR_W-1:0] byte_address,
  input  logic [ubmm_pkg::DATA_W-1:0] write_data,
  input  logic [ubmm_pkg::BE_W-1:0]   byte_enable,
  output logic                        done,
  output logic [ubmm_pkg::DATA_W-1:0] read_data,
  output logic                        access_error
);

  // The store is split into an even-word bank and an odd-word bank. An
  // unaligned access always spans one word of each, so both are read in the
  // same cycle and written back together.
  localparam int MEM_WORDS  = MEM_BYTES / 4;
  localparam int SPAN       = MEM_WORDS * 4;
  localparam int EVEN_DEPTH = (MEM_WORDS + 1) / 2;
  localparam int ODD_DEPTH  = MEM_WORDS / 2;
  localparam int BANK_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
  localparam int IDX_W      = $clog2(MEM_WORDS);

  // Captured beat.
  logic                        req_cmd;
  logic [ubmm_pkg::ADDR_W-1:0] req_addr;
  logic [ubmm_pkg::DATA_W-1:0] req_data;
  logic [ubmm_pkg::BE_W-1:0]   req_be;

  ubmm_pkg::state_t state;
  ubmm_pkg::state_t state_next;

  logic [BANK_AW-1:0]          clr_addr;
  logic                        clr_last;

  logic [ubmm_pkg::ADDR_W-1:0] addr_mod;
  logic [IDX_W-1:0]            word_idx;
  logic [1:0]                  offset;
  logic                        addr_err;
  logic [BANK_AW-1:0]          even_addr;
  logic [BANK_AW-1:0]          odd_addr;
  ubmm_pkg::lane_sel_t         sel;

  logic                        even_we;
  logic                        odd_we;
  logic [BANK_AW-1:0]          even_wr_addr;
  logic [BANK_AW-1:0]          odd_wr_addr;
  logic [ubmm_pkg::DATA_W-1:0] even_wr_data;
  logic [ubmm_pkg::DATA_W-1:0] odd_wr_data;
  logic [ubmm_pkg::DATA_W-1:0] even_q;
  logic [ubmm_pkg::DATA_W-1:0] odd_q;
  logic [ubmm_pkg::DATA_W-1:0] merge_rdata;
  logic [ubmm_pkg::DATA_W-1:0] new_even;
  logic [ubmm_pkg::DATA_W-1:0] new_odd;

  logic                        done_next;
  logic [ubmm_pkg::DATA_W-1:0] read_data_next;
  logic                        access_error_next;

  // The reduction pipeline runs freely on the held address; the controller
  // simply waits through the reduce and index states for its result to settle.
  ubmm_addr_reduce #(
    .SPAN (SPAN)
  ) u_reduce (
    .clk      (clk),
    .addr     (req_addr),
    .addr_mod (addr_mod)
  );

  // Word index and byte offset of the reduced address. The first word sits
  // in the odd bank when the index is odd; the second word is always the
  // other bank, at the index plus one.
  assign word_idx  = IDX_W'(32'(addr_mod) >> 2);
  assign offset    = addr_mod[1:0];
  assign addr_err  = (offset != 2'd0) && ((32'(word_idx) + 32'd1) >= 32'(MEM_WORDS));
  assign even_addr = BANK_AW'((32'(word_idx) + 32'd1) >> 1);
  assign odd_addr  = BANK_AW'(32'(word_idx) >> 1);

  assign sel.first_odd = word_idx[0];
  assign sel.offset    = offset;

  assign clr_last = (clr_addr == BANK_AW'(EVEN_DEPTH - 1));

  ubmm_bank #(
    .DEPTH (EVEN_DEPTH),
    .AW    (BANK_AW)
  ) u_even (
    .clk     (clk),
    .we      (even_we),
    .wr_addr (even_wr_addr),
    .wr_data (even_wr_data),
    .rd_addr (even_addr),
    .rd_data (even_q)
  );

  ubmm_bank #(
    .DEPTH (ODD_DEPTH),
    .AW    (BANK_AW)
  ) u_odd (
    .clk     (clk),
    .we      (odd_we),
    .wr_addr (odd_wr_addr),
    .wr_data (odd_wr_data),
    .rd_addr (odd_addr),
    .rd_data (odd_q)
  );

  ubmm_merge u_merge (
    .sel         (sel),
    .even_word   (even_q),
    .odd_word    (odd_q),
    .write_data  (req_data),
    .byte_enable (req_be),
    .read_data   (merge_rdata),
    .new_even    (new_even),
    .new_odd     (new_odd)
  );

  // Next state. Only one access is in flight, and its write-back lands at the
  // edge that leaves the modify state, before any later read is issued, so
  // read-after-write needs neither forwarding nor an interlock.
  always_comb begin
    state_next = state;
    case (state)
      ubmm_pkg::ST_CLEAR:  if (clr_last) state_next = ubmm_pkg::ST_IDLE;
      ubmm_pkg::ST_IDLE:   if (start) state_next = ubmm_pkg::ST_REDUCE;
      ubmm_pkg::ST_REDUCE: state_next = ubmm_pkg::ST_INDEX;
      ubmm_pkg::ST_INDEX:  state_next = ubmm_pkg::ST_READ;
      ubmm_pkg::ST_READ:   state_next = ubmm_pkg::ST_MODIFY;
      ubmm_pkg::ST_MODIFY: state_next = ubmm_pkg::ST_IDLE;
      default:             state_next = ubmm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: bank writes and the result beat.
  always_comb begin
    busy              = (state != ubmm_pkg::ST_IDLE);
    even_we           = 1'b0;
    odd_we            = 1'b0;
    even_wr_addr      = even_addr;
    odd_wr_addr       = odd_addr;
    even_wr_data      = new_even;
    odd_wr_data       = new_odd;
    done_next         = 1'b0;
    read_data_next    = '0;
    access_error_next = 1'b0;
    case (state)
      ubmm_pkg::ST_CLEAR: begin
        even_we      = 1'b1;
        odd_we       = (32'(clr_addr) < 32'(ODD_DEPTH));
        even_wr_addr = clr_addr;
        odd_wr_addr  = clr_addr;
        even_wr_data = '0;
        odd_wr_data  = '0;
      end
      ubmm_pkg::ST_MODIFY: begin
        // The bank holding the first word is always written; the other one
        // only when the access actually spans into it.
        if (req_cmd == ubmm_pkg::CMD_WRITE && !addr_err) begin
          even_we = !word_idx[0] || (offset != 2'd0);
          odd_we  = word_idx[0] || (offset != 2'd0);
        end
        done_next         = 1'b1;
        access_error_next = addr_err;
        if (req_cmd == ubmm_pkg::CMD_READ && !addr_err) begin
          read_data_next = merge_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ubmm_pkg::ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ubmm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + BANK_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    read_data    <= read_data_next;
    access_error <= access_error_next;
    if (state == ubmm_pkg::ST_IDLE && start) begin
      req_cmd  <= command;
      req_addr <= byte_address;
      req_data <= write_data;
      req_be   <= byte_enable;
    end
  end

endmodule

@@ tb/ubmm_access_checker.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: access checker
// Watches accepted beats and result strobes and keeps a shadow copy of the
// word store. It predicts each result and compares it field by field, in
// order, with what the block returns.
// ----------------------------------------------------------------------------
module ubmm_access_checker #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        command,
  input  logic [ubmm_pkg::ADDR_W-1:0] byte_address,
  input  logic [ubmm_pkg::DATA_W-1:0] write_data,
  input  logic [ubmm_pkg::BE_W-1:0]   byte_enable,
  input  logic                        done,
  input  logic [ubmm_pkg::DATA_W-1:0] read_data,
  input  logic                        access_error,
  output int                          error_count,
  output int                          pending_beats
);

  localparam int WORDS = MEM_BYTES / 4;

  typedef struct packed {
    logic [ubmm_pkg::DATA_W-1:0] data;
    logic                        err;
  } access_result_t;

  logic [ubmm_pkg::DATA_W-1:0] shadow_words [0:WORDS-1];
  access_result_t              expected_results [$];

  // Applies one access to the shadow store and returns what the block
  // should report for it.
  function automatic access_result_t perform_access(
    input logic                        is_write,
    input logic [ubmm_pkg::ADDR_W-1:0] addr,
    input logic [ubmm_pkg::DATA_W-1:0] data,
    input logic [ubmm_pkg::BE_W-1:0]   enable
  );
    access_result_t res;
    int             wrapped;
    int             idx;
    int             nxt;
    int             off;
    logic [7:0]     lane_en;
    logic [63:0]    lane_data;
    logic [63:0]    pair;
    res     = '0;
    wrapped = int'(addr) % (WORDS * 4);
    idx     = wrapped / 4;
    off     = wrapped % 4;
    nxt     = (off == 0) ? idx : idx + 1;
    if (off != 0 && idx + 1 >= WORDS) begin
      res.err = 1'b1;
    end else if (is_write == ubmm_pkg::CMD_WRITE) begin
      lane_en   = 8'(enable) << off;
      lane_data = 64'(data) << (8 * off);
      for (int i = 0; i < 8; i++) begin
        if (lane_en[i]) begin
          shadow_words[idx + i / 4][8 * (i % 4) +: 8] = lane_data[8 * i +: 8];
        end
      end
    end else begin
      pair     = {shadow_words[nxt], shadow_words[idx]};
      res.data = pair[8 * off +: 32];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < WORDS; i++) begin
        shadow_words[i] = '0;
      end
      expected_results.delete();
      error_count   = 0;
      pending_beats = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: read_data %h access_error %b",
                 read_data, access_error);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.data) begin
            $error("read_data: expected %h, actual %h", want.data, read_data);
            error_count++;
          end
          if (access_error !== want.err) begin
            $error("access_error: expected %b, actual %b", want.err, access_error);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(
          perform_access(command, byte_address, write_data, byte_enable));
      end
      pending_beats = expected_results.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Unaligned byte-masked memory: testbench top
// Drives read and byte-masked write beats in bursts with random gaps: first a
// directed set covering aligned and unaligned lanes, the top-word error and
// zero enables, then random traffic concentrated on a small window so that
// reads often return earlier writes. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MEM_BYTES    = 4096;
  localparam int RANDOM_BEATS = 750;
  // The slowest correct run (clearing pass, all beats and the longest gaps)
  // ends far below this limit, so it leaves a wide margin.
  localparam int CYCLE_LIMIT  = 200000;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        command;
  logic [ubmm_pkg::ADDR_W-1:0] byte_address;
  logic [ubmm_pkg::DATA_W-1:0] write_data;
  logic [ubmm_pkg::BE_W-1:0]   byte_enable;
  logic                        done;
  logic [ubmm_pkg::DATA_W-1:0] read_data;
  logic                        access_error;
  int                          error_count;
  int                          pending_beats;
  int                          cycle_count;

  unaligned_byte_masked_memory_top #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .byte_address(byte_address),
    .write_data  (write_data),
    .byte_enable (byte_enable),
    .done        (done),
    .read_data   (read_data),
    .access_error(access_error)
  );

  ubmm_access_checker #(
    .MEM_BYTES(MEM_BYTES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .byte_address (byte_address),
    .write_data   (write_data),
    .byte_enable  (byte_enable),
    .done         (done),
    .read_data    (read_data),
    .access_error (access_error),
    .error_count  (error_count),
    .pending_beats(pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Presents one beat at the falling edge and holds it until a rising edge
  // sees start high with busy low. Back-to-back beats simply leave start high.
  task automatic send_beat(
    input logic                        cmd,
    input logic [ubmm_pkg::ADDR_W-1:0] addr,
    input logic [ubmm_pkg::DATA_W-1:0] data,
    input logic [ubmm_pkg::BE_W-1:0]   enable
  );
    @(negedge clk);
    start        = 1'b1;
    command      = cmd;
    byte_address = addr;
    write_data   = data;
    byte_enable  = enable;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Leaves start low for the given number of cycles.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Stops sending until every outstanding beat has produced its result.
  task automatic drain_results();
    hold_off(1);
    while (pending_beats != 0) @(negedge clk);
  endtask

  // Most random addresses fall in a small window so that reads meet earlier
  // writes; some land near the top word to reach the overrun error, and the
  // rest cover the whole address range.
  function automatic logic [ubmm_pkg::ADDR_W-1:0] pick_address();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return ubmm_pkg::ADDR_W'(12'h100 + $urandom_range(0, 63));
    end else if (pick < 75) begin
      return ubmm_pkg::ADDR_W'(12'hff0 + $urandom_range(0, 15));
    end else begin
      return ubmm_pkg::ADDR_W'($urandom);
    end
  endfunction

  initial begin
    int burst_left;
    rst          = 1'b1;
    start        = 1'b0;
    command      = ubmm_pkg::CMD_READ;
    byte_address = '0;
    write_data   = '0;
    byte_enable  = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed part. Reads of the cleared store, the overrun error at the
    // top word for reads and for writes with and without enables, every
    // byte offset, a zero enable, and legal accesses that touch the top word.
    send_beat(ubmm_pkg::CMD_READ,  12'h000, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'hfff, 32'h0000_0000, 4'hf);
    send_beat(ubmm_pkg::CMD_READ,  12'hffc, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_WRITE, 12'h000, 32'hffff_ffff, 4'hf);
    send_beat(ubmm_pkg::CMD_READ,  12'h000, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_WRITE, 12'h011, 32'h1122_3344, 4'hf);
    send_beat(ubmm_pkg::CMD_WRITE, 12'h022, 32'ha5a5_a5a5, 4'h5);
    send_beat(ubmm_pkg::CMD_WRITE, 12'h033, 32'hdead_beef, 4'ha);
    send_beat(ubmm_pkg::CMD_WRITE, 12'h040, 32'h1234_5678, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h011, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h010, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h014, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h022, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h033, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h034, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'h040, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_WRITE, 12'hffd, 32'hffff_ffff, 4'hf);
    send_beat(ubmm_pkg::CMD_WRITE, 12'hffe, 32'hffff_ffff, 4'h0);
    send_beat(ubmm_pkg::CMD_WRITE, 12'hffc, 32'hcafe_f00d, 4'hf);
    send_beat(ubmm_pkg::CMD_READ,  12'hffc, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'hffb, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_WRITE, 12'hff9, 32'h55aa_55aa, 4'hf);
    send_beat(ubmm_pkg::CMD_READ,  12'hffc, 32'h0000_0000, 4'h0);
    send_beat(ubmm_pkg::CMD_READ,  12'hff8, 32'h0000_0000, 4'h0);

    // Let the pipeline empty completely once before the random traffic.
    drain_results();

    // Random part, sent in bursts. A quarter of the bursts start straight after
    // the last; the others are preceded by a gap of random length, so idle
    // cycles land on every phase of the block's work.
    burst_left = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) begin
          hold_off($urandom_range(1, 12));
        end
      end
      burst_left--;
      if (n == RANDOM_BEATS / 2) begin
        drain_results();
      end
      send_beat($urandom_range(0, 1) ? ubmm_pkg::CMD_WRITE : ubmm_pkg::CMD_READ,
                pick_address(), $urandom, ubmm_pkg::BE_W'($urandom_range(0, 15)));
    end
    hold_off(1);

    // Wait for the last results, then keep the clock running to catch any stray strobe.
    while (pending_beats != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ubmm_pkg.sv
sv/ubmm_bank.sv
sv/ubmm_addr_reduce.sv
sv/ubmm_merge.sv
sv/unaligned_byte_masked_memory_top.sv
tb/ubmm_access_checker.sv
tb/tb_top.sv
